// ===== rtl/core/btbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text buffer engine package
// Shared types, field widths, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package btbe_pkg;

    localparam int DEPTH_DEF   = 32;
    localparam int PAT_MAX_DEF = 8;

    localparam int FUNC_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 6;
    localparam int INDEX_W = 5;
    localparam int COUNT_W = 6;
    localparam int LEN_W   = 6;

    typedef enum logic [FUNC_W-1:0] {
        FN_INIT    = 3'd0,
        FN_INSERT  = 3'd1,
        FN_DELETE  = 3'd2,
        FN_REPLACE = 3'd3,
        FN_FIND    = 3'd4,
        FN_COUNT   = 3'd5,
        FN_PATTERN = 3'd6
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_INS_WRITE,
        ST_DEL_SHIFT,
        ST_SCAN,
        ST_SUB_RD,
        ST_SUB_CMP
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  pos_end;
        logic              last;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
        logic [LEN_W-1:0]   length;
        logic               status;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/btbe_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module btbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/bounded_text_buffer_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded text buffer engine
// Byte string kept in a text RAM, with a pattern RAM for substring search.
// Init, replace, rejects, direct insert, no-move delete, empty find/count and pattern
// chars needing no search raise done in the cycle after start. Insert shifts the tail
// right, then writes; delete shifts left; find/count make one text RAM read per cycle.
// Substring reads, then compares. One request at a time; start taken when busy is low.
// Reset clears length and pattern count; RAM content beyond length is never used.
// ----------------------------------------------------------------------------
module bounded_text_buffer_engine_core #(
    parameter int DEPTH   = btbe_pkg::DEPTH_DEF,
    parameter int PAT_MAX = btbe_pkg::PAT_MAX_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  btbe_pkg::req_t request,
    output logic           busy,
    output logic           done,
    output btbe_pkg::rsp_t result
);
    import btbe_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int LW  = $clog2(DEPTH + 1);
    localparam int SW  = LW + 1;
    localparam int CW  = (LW > POS_W) ? LW : POS_W;
    localparam int PAW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int PW  = $clog2(PAT_MAX + 1);

    state_t              state_reg, state_next;
    logic [LW-1:0]       length_reg, length_next;
    logic [PW-1:0]       pat_len_reg, pat_len_next;
    logic [FUNC_W-1:0]   op_reg, op_next;
    logic [CHAR_W-1:0]   ch_reg, ch_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [LW-1:0]       gap_reg, gap_next;
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [LW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       i_reg, i_next;
    logic [PAW-1:0]      j_reg, j_next;
    logic [PW-1:0]       plen_reg, plen_next;
    logic                done_reg, done_next;
    rsp_t                result_reg, result_next;

    logic                t_we;
    logic [AW-1:0]       t_waddr, t_raddr;
    logic [CHAR_W-1:0]   t_wdata, t_rdata;
    logic                p_we;
    logic [PAW-1:0]      p_waddr, p_raddr;
    logic [CHAR_W-1:0]   p_wdata, p_rdata;

    logic                acc;
    logic [CW-1:0]       pos_c, pend_c, len_c;
    logic                ins_bad, ins_direct, del_bad, del_nomove, rep_bad;
    logic                len_zero, pat_full, sub_nostart;
    logic                ins_step_end, del_end, scan_hit, scan_end;
    logic                sub_eq, sub_last_j, sub_last_i;
    logic [LW-1:0]       cnt_sum;

    logic                fin;
    logic                r_found, r_status;
    logic [LW-1:0]       r_index, r_count;

    btbe_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_text_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    btbe_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (PAT_MAX),
        .AW    (PAW)
    ) u_pat_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign acc    = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign pos_c  = CW'(request.pos);
    assign pend_c = CW'(request.pos_end);
    assign len_c  = CW'(length_reg);

    assign ins_bad     = (pos_c > len_c) || (length_reg == LW'(DEPTH));
    assign ins_direct  = (pos_c == len_c);
    assign del_bad     = (pos_c > pend_c) || (pend_c > len_c);
    assign del_nomove  = (pos_c == pend_c) || (pend_c == len_c);
    assign rep_bad     = (pos_c >= len_c);
    assign len_zero    = (length_reg == '0);
    assign pat_full    = (pat_len_reg >= PW'(PAT_MAX));
    assign sub_nostart = (SW'(pat_len_reg) + SW'(1)) > SW'(length_reg);

    assign ins_step_end = (wr_ptr_reg == pos_reg + AW'(1));
    assign del_end      = (rd_ptr_reg == length_reg);
    assign scan_hit     = (t_rdata == ch_reg);
    assign scan_end     = (SW'(rd_ptr_reg) + SW'(1)) == SW'(length_reg);
    assign cnt_sum      = cnt_reg + LW'(scan_hit);
    assign sub_eq       = (t_rdata == p_rdata);
    assign sub_last_j   = (SW'(j_reg) + SW'(1)) == SW'(plen_reg);
    assign sub_last_i   = (SW'(i_reg) + SW'(plen_reg)) == SW'(length_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    unique case (request.func)
                        FN_INSERT:
                        begin
                            if (!ins_bad && !ins_direct)
                            begin
                                state_next = ST_INS_SHIFT;
                            end
                        end
                        FN_DELETE:
                        begin
                            if (!del_bad && !del_nomove)
                            begin
                                state_next = ST_DEL_SHIFT;
                            end
                        end
                        FN_FIND, FN_COUNT:
                        begin
                            if (!len_zero)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        FN_PATTERN:
                        begin
                            if (!pat_full && request.last && !sub_nostart)
                            begin
                                state_next = ST_SUB_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INS_SHIFT:
            begin
                if (ins_step_end)
                begin
                    state_next = ST_INS_WRITE;
                end
            end
            ST_INS_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_DEL_SHIFT:
            begin
                if (del_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_end || ((op_reg == FN_FIND) && scan_hit))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUB_RD:
            begin
                state_next = ST_SUB_CMP;
            end
            ST_SUB_CMP:
            begin
                if ((sub_eq && sub_last_j) || (!sub_eq && sub_last_i))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SUB_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath, memory ports and result
    always_comb
    begin
        t_we         = 1'b0;
        t_waddr      = '0;
        t_wdata      = '0;
        t_raddr      = '0;
        p_we         = 1'b0;
        p_waddr      = '0;
        p_wdata      = '0;
        p_raddr      = j_reg;
        length_next  = length_reg;
        pat_len_next = pat_len_reg;
        op_next      = op_reg;
        ch_next      = ch_reg;
        pos_next     = pos_reg;
        gap_next     = gap_reg;
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        plen_next    = plen_reg;
        fin          = 1'b0;
        r_found      = 1'b0;
        r_status     = 1'b0;
        r_index      = '0;
        r_count      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    op_next = request.func;
                    ch_next = request.ch;
                    unique case (request.func)
                        FN_INIT:
                        begin
                            t_we         = 1'b1;
                            t_waddr      = '0;
                            t_wdata      = request.ch;
                            length_next  = LW'(1);
                            pat_len_next = '0;
                            fin          = 1'b1;
                        end
                        FN_INSERT:
                        begin
                            if (ins_bad)
                            begin
                                r_status = 1'b1;
                                fin      = 1'b1;
                            end
                            else if (ins_direct)
                            begin
                                t_we        = 1'b1;
                                t_waddr     = AW'(request.pos);
                                t_wdata     = request.ch;
                                length_next = length_reg + LW'(1);
                                fin         = 1'b1;
                            end
                            else
                            begin
                                // walk the tail right, last char first
                                t_raddr     = AW'(length_reg - LW'(1));
                                wr_ptr_next = AW'(length_reg);
                                pos_next    = AW'(request.pos);
                            end
                        end
                        FN_DELETE:
                        begin
                            if (del_bad)
                            begin
                                r_status = 1'b1;
                                fin      = 1'b1;
                            end
                            else if (del_nomove)
                            begin
                                length_next = LW'(len_c - (pend_c - pos_c));
                                fin         = 1'b1;
                            end
                            else
                            begin
                                t_raddr     = AW'(request.pos_end);
                                rd_ptr_next = LW'(pend_c + CW'(1));
                                wr_ptr_next = AW'(request.pos);
                                gap_next    = LW'(pend_c - pos_c);
                            end
                        end
                        FN_REPLACE:
                        begin
                            if (rep_bad)
                            begin
                                r_status = 1'b1;
                            end
                            else
                            begin
                                t_we    = 1'b1;
                                t_waddr = AW'(request.pos);
                                t_wdata = request.ch;
                            end
                            fin = 1'b1;
                        end
                        FN_FIND, FN_COUNT:
                        begin
                            if (len_zero)
                            begin
                                fin = 1'b1;
                            end
                            t_raddr     = '0;
                            rd_ptr_next = '0;
                            cnt_next    = '0;
                        end
                        FN_PATTERN:
                        begin
                            if (pat_full)
                            begin
                                // drop the char
                                r_status = 1'b1;
                                if (request.last)
                                begin
                                    pat_len_next = '0;
                                end
                                fin = 1'b1;
                            end
                            else
                            begin
                                p_we    = 1'b1;
                                p_waddr = pat_len_reg[PAW-1:0];
                                p_wdata = request.ch;
                                if (!request.last)
                                begin
                                    pat_len_next = pat_len_reg + PW'(1);
                                    fin          = 1'b1;
                                end
                                else
                                begin
                                    pat_len_next = '0;
                                    plen_next    = pat_len_reg + PW'(1);
                                    i_next       = '0;
                                    j_next       = '0;
                                    if (sub_nostart)
                                    begin
                                        fin = 1'b1;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            r_status = 1'b1;
                            fin      = 1'b1;
                        end
                    endcase
                end
            end
            ST_INS_SHIFT:
            begin
                t_we        = 1'b1;
                t_waddr     = wr_ptr_reg;
                t_wdata     = t_rdata;
                t_raddr     = wr_ptr_reg - AW'(2);
                wr_ptr_next = wr_ptr_reg - AW'(1);
            end
            ST_INS_WRITE:
            begin
                t_we        = 1'b1;
                t_waddr     = pos_reg;
                t_wdata     = ch_reg;
                length_next = length_reg + LW'(1);
                fin         = 1'b1;
            end
            ST_DEL_SHIFT:
            begin
                t_we    = 1'b1;
                t_waddr = wr_ptr_reg;
                t_wdata = t_rdata;
                t_raddr = rd_ptr_reg[AW-1:0];
                if (del_end)
                begin
                    length_next = length_reg - gap_reg;
                    fin         = 1'b1;
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg + LW'(1);
                    wr_ptr_next = wr_ptr_reg + AW'(1);
                end
            end
            ST_SCAN:
            begin
                // rd_ptr holds the address of the char on t_rdata
                t_raddr     = AW'(rd_ptr_reg + LW'(1));
                rd_ptr_next = rd_ptr_reg + LW'(1);
                cnt_next    = cnt_sum;
                if ((op_reg == FN_FIND) && scan_hit)
                begin
                    r_found = 1'b1;
                    r_index = rd_ptr_reg;
                    fin     = 1'b1;
                end
                else if (scan_end)
                begin
                    if (op_reg == FN_COUNT)
                    begin
                        r_count = cnt_sum;
                    end
                    fin = 1'b1;
                end
            end
            ST_SUB_RD:
            begin
                t_raddr = AW'(LW'(i_reg) + LW'(j_reg));
                p_raddr = j_reg;
            end
            ST_SUB_CMP:
            begin
                if (sub_eq)
                begin
                    if (sub_last_j)
                    begin
                        r_found = 1'b1;
                        r_index = LW'(i_reg);
                        fin     = 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + PAW'(1);
                    end
                end
                else if (sub_last_i)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    // advance the start, restart the pattern
                    i_next = i_reg + AW'(1);
                    j_next = '0;
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase

        done_next          = fin;
        result_next        = result_reg;
        if (fin)
        begin
            result_next.found  = r_found;
            result_next.index  = INDEX_W'(r_index);
            result_next.count  = COUNT_W'(r_count);
            result_next.length = LEN_W'(length_next);
            result_next.status = r_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            length_reg  <= '0;
            pat_len_reg <= '0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            length_reg  <= length_next;
            pat_len_reg <= pat_len_next;
            done_reg    <= done_next;
            result_reg  <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        ch_reg     <= ch_next;
        pos_reg    <= pos_next;
        gap_reg    <= gap_next;
        wr_ptr_reg <= wr_ptr_next;
        rd_ptr_reg <= rd_ptr_next;
        cnt_reg    <= cnt_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        plen_reg   <= plen_next;
    end

endmodule

`default_nettype wire
